FILE: src/mtfm_pkg.sv
package mtfm_pkg;

   localparam int MAX_SUBS_DEF      = 8;
   localparam int MAX_TOPIC_LEN_DEF = 64;

   // word field widths
   localparam int CMD_W   = 3;
   localparam int SUB_W   = 3;
   localparam int POS_W   = 7;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 4;
   localparam int IDX_W   = 3;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COUNT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TOPIC = 3'd3;
   localparam logic [CMD_W-1:0] CMD_EMPTY = 3'd4;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

   // result queue depth
   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_LEVEL,
      MODE_REST,
      MODE_FAIL
   } mode_type;

   typedef struct packed {
      logic              step;
      logic [CHAR_W-1:0] topic_byte;
      logic              restart;
      logic              fin_last;
      logic              fin_empty;
   } lane_ctl_type;

   typedef struct packed {
      logic             matched;
      logic [IDX_W-1:0] first_match_res;
      logic             topic_too_long;
   } rsp_type;

endpackage

FILE: src/mtfm_if.sv
interface mtfm_req_if;
   import mtfm_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [SUB_W-1:0]   sub_index;
   logic [POS_W-1:0]   char_pos;
   logic [CHAR_W-1:0]  char_value;
   logic [COUNT_W-1:0] count_value;
   logic               is_last;

   modport source (
      output valid, cmd, sub_index, char_pos, char_value, count_value, is_last,
      input  ready
   );

   modport sink (
      input  valid, cmd, sub_index, char_pos, char_value, count_value, is_last,
      output ready
   );
endinterface

interface mtfm_rsp_if;
   import mtfm_pkg::*;

   logic             valid;
   logic             ready;
   logic             matched;
   logic [IDX_W-1:0] first_match_res;
   logic             topic_too_long;

   modport source (
      output valid, matched, first_match_res, topic_too_long,
      input  ready
   );

   modport sink (
      input  valid, matched, first_match_res, topic_too_long,
      output ready
   );
endinterface

FILE: src/mtfm_ram.sv
module mtfm_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 65,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: src/mtfm_lane.sv
module mtfm_lane #(
   parameter int  MAX_TOPIC_LEN = mtfm_pkg::MAX_TOPIC_LEN_DEF,
   localparam int ROW_LEN       = MAX_TOPIC_LEN + 1,
   localparam int AW            = $clog2(ROW_LEN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mtfm_pkg::lane_ctl_type     ctl,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [mtfm_pkg::CHAR_W-1:0] wr_data,
   output logic                       hit
);
   import mtfm_pkg::*;

   localparam int CUR_W = $clog2(ROW_LEN + 2);

   logic [CUR_W-1:0]  cursor_ff;
   logic [CUR_W-1:0]  cursor_in;
   logic [CUR_W-1:0]  post_cursor;
   logic [CUR_W-1:0]  rd_addr_a;
   logic [CUR_W-1:0]  rd_addr_b;
   mode_type          mode_ff;
   mode_type          mode_in;
   mode_type          post_mode;
   mode_type          pend_mode_ff;
   logic              fresh_ff;
   logic              pend_sh_ff;
   logic [CHAR_W-1:0] shadow_ff [2];
   logic [CHAR_W-1:0] wdata_ff;
   logic              fwd_a_ff;
   logic              fwd_b_ff;
   logic              oor_a_ff;
   logic              oor_b_ff;
   logic              oor_a;
   logic              oor_b;
   logic [CHAR_W-1:0] ram_a;
   logic [CHAR_W-1:0] ram_b;
   logic [CHAR_W-1:0] mem_a;
   logic [CHAR_W-1:0] mem_b;
   logic [CHAR_W-1:0] c0;
   logic [CHAR_W-1:0] c1;
   logic [CHAR_W-1:0] e0;
   logic [CHAR_W-1:0] e1;

   // on a topic end the memory fetches the final cursor for the match check;
   // the next topic starts from the shadow copy of the first two characters
   assign rd_addr_a = ctl.fin_last ? post_cursor : cursor_in;
   assign rd_addr_b = rd_addr_a + CUR_W'(1);
   assign oor_a     = rd_addr_a >= CUR_W'(ROW_LEN);
   assign oor_b     = rd_addr_b >= CUR_W'(ROW_LEN);

   mtfm_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (ROW_LEN)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a[AW-1:0]),
      .rd_data_a (ram_a),
      .rd_addr_b (rd_addr_b[AW-1:0]),
      .rd_data_b (ram_b)
   );

   always_ff @(posedge clock) begin
      fwd_a_ff <= wr_en && !oor_a && (wr_addr == rd_addr_a[AW-1:0]);
      fwd_b_ff <= wr_en && !oor_b && (wr_addr == rd_addr_b[AW-1:0]);
      oor_a_ff <= oor_a;
      oor_b_ff <= oor_b;
      wdata_ff <= wr_data;
      if (wr_en && (wr_addr < AW'(2))) begin
         shadow_ff[wr_addr[0]] <= wr_data;
      end
   end

   assign mem_a = oor_a_ff ? CH_NUL : (fwd_a_ff ? wdata_ff : ram_a);
   assign mem_b = oor_b_ff ? CH_NUL : (fwd_b_ff ? wdata_ff : ram_b);
   assign c0    = fresh_ff ? shadow_ff[0] : mem_a;
   assign c1    = fresh_ff ? shadow_ff[1] : mem_b;
   assign e0    = pend_sh_ff ? shadow_ff[0] : mem_a;
   assign e1    = pend_sh_ff ? shadow_ff[1] : mem_b;

   // cursor step for one topic byte
   always_comb begin
      post_cursor = cursor_ff;
      post_mode   = mode_ff;
      if (ctl.step) begin
         case (mode_ff)
            MODE_NORMAL: begin
               if (c0 == CH_HASH) begin
                  post_mode = MODE_REST;
               end else if (c0 == CH_PLUS) begin
                  if (ctl.topic_byte == CH_SLASH) begin
                     // empty level: the '+' must be followed by '/'
                     if (c1 == CH_SLASH) begin
                        post_cursor = cursor_ff + CUR_W'(2);
                     end else begin
                        post_mode = MODE_FAIL;
                     end
                  end else begin
                     post_cursor = cursor_ff + CUR_W'(1);
                     post_mode   = MODE_LEVEL;
                  end
               end else if ((c0 == CH_NUL) || (c0 != ctl.topic_byte)) begin
                  post_mode = MODE_FAIL;
               end else begin
                  post_cursor = cursor_ff + CUR_W'(1);
               end
            end
            MODE_LEVEL: begin
               if (ctl.topic_byte == CH_SLASH) begin
                  if (c0 == CH_SLASH) begin
                     post_cursor = cursor_ff + CUR_W'(1);
                     post_mode   = MODE_NORMAL;
                  end else begin
                     post_mode = MODE_FAIL;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cursor_in = ctl.restart ? '0 : post_cursor;
      mode_in   = ctl.restart ? MODE_NORMAL : post_mode;
   end

   // end-of-topic check, in the cycle after the finishing word
   always_comb begin
      case (pend_mode_ff)
         MODE_NORMAL: hit = (e0 == CH_HASH) || (e0 == CH_NUL) ||
                            ((e0 == CH_PLUS) && (e1 == CH_NUL));
         MODE_LEVEL:  hit = (e0 == CH_NUL);
         MODE_REST:   hit = 1'b1;
         default:     hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         mode_ff      <= MODE_NORMAL;
         fresh_ff     <= 1'b1;
         pend_sh_ff   <= 1'b0;
         pend_mode_ff <= MODE_NORMAL;
      end else begin
         cursor_ff    <= cursor_in;
         mode_ff      <= mode_in;
         fresh_ff     <= ctl.restart;
         pend_sh_ff   <= ctl.fin_empty;
         pend_mode_ff <= ctl.fin_empty ? MODE_NORMAL : post_mode;
      end
   end

endmodule

FILE: src/mtfm_rsp_fifo.sv
module mtfm_rsp_fifo (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         push,
   input  mtfm_pkg::rsp_type                            push_data,
   input  logic                                         pop,
   output mtfm_pkg::rsp_type                            head,
   output logic [$clog2(mtfm_pkg::RSP_DEPTH + 1)-1:0]   count
);
   import mtfm_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_type            entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

FILE: src/mqtt_topic_filter_matcher.sv
// One word per cycle while the result queue has room: every filter lane steps
// its cursor in parallel against its own filter memory, prefetching the next
// two characters. The last topic word's result is registered as pending, then
// pushed into a four-entry queue that keeps the input open while results wait.
// Synchronous active-high reset clears counts, cursors and the queue;
// filter characters are not cleared and need no clearing pass.
module mqtt_topic_filter_matcher #(
   parameter int MAX_SUBS      = mtfm_pkg::MAX_SUBS_DEF,
   parameter int MAX_TOPIC_LEN = mtfm_pkg::MAX_TOPIC_LEN_DEF
) (
   input logic        clock,
   input logic        reset,
   mtfm_req_if.sink   req_bus,
   mtfm_rsp_if.source rsp_bus
);
   import mtfm_pkg::*;

   localparam int ROW_LEN = MAX_TOPIC_LEN + 1;
   localparam int AW      = $clog2(ROW_LEN);
   localparam int LEN_W   = $clog2(MAX_TOPIC_LEN + 2);
   localparam int ACT_W   = $clog2(MAX_SUBS + 1);
   localparam int QCNT_W  = $clog2(RSP_DEPTH + 1);

   logic               accept;
   logic               is_topic;
   logic               is_empty;
   logic               write_ok;
   lane_ctl_type       ctl;
   logic [AW-1:0]      wr_addr;
   logic [MAX_SUBS-1:0] hit_vec;

   logic [ACT_W-1:0]   active_ff;
   logic [ACT_W-1:0]   active_in;
   logic [ACT_W-1:0]   count_sat;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic [LEN_W-1:0]   len_inc;
   logic               ended_ff;
   logic               ended_in;

   logic               pend_valid_ff;
   logic [ACT_W-1:0]   pend_count_ff;
   logic               pend_long_ff;

   rsp_type            fin_rsp;
   rsp_type            head;
   logic [QCNT_W-1:0]  q_count;
   logic               pop;

   // room is kept for every result already in flight plus this one
   assign req_bus.ready = (q_count + QCNT_W'(pend_valid_ff)) < QCNT_W'(RSP_DEPTH);
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_topic      = accept && (req_bus.cmd == CMD_TOPIC);
   assign is_empty      = accept && (req_bus.cmd == CMD_EMPTY);
   assign write_ok      = accept && (req_bus.cmd == CMD_WRITE) &&
                          (int'(req_bus.sub_index) < MAX_SUBS) &&
                          (int'(req_bus.char_pos) < ROW_LEN);
   assign wr_addr       = AW'(req_bus.char_pos);

   always_comb begin
      ctl.step       = is_topic && !ended_ff && (req_bus.char_value != CH_NUL);
      ctl.topic_byte = req_bus.char_value;
      ctl.fin_last   = is_topic && req_bus.is_last;
      ctl.fin_empty  = is_empty;
      ctl.restart    = (is_topic && req_bus.is_last) || is_empty;
   end

   for (genvar s = 0; s < MAX_SUBS; s++) begin : g_lane
      mtfm_lane #(
         .MAX_TOPIC_LEN (MAX_TOPIC_LEN)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .wr_en   (write_ok && (int'(req_bus.sub_index) == s)),
         .wr_addr (wr_addr),
         .wr_data (req_bus.char_value),
         .hit     (hit_vec[s])
      );
   end

   // topic length saturates one past the limit
   assign len_inc   = (len_ff <= LEN_W'(MAX_TOPIC_LEN)) ? len_ff + LEN_W'(1) : len_ff;
   assign count_sat = (int'(req_bus.count_value) > MAX_SUBS) ?
                      ACT_W'(MAX_SUBS) : ACT_W'(req_bus.count_value);

   always_comb begin
      active_in = active_ff;
      if (accept && (req_bus.cmd == CMD_CLEAR)) begin
         active_in = '0;
      end else if (accept && (req_bus.cmd == CMD_COUNT)) begin
         active_in = count_sat;
      end
   end

   always_comb begin
      len_in   = len_ff;
      ended_in = ended_ff;
      if (ctl.restart) begin
         len_in   = '0;
         ended_in = 1'b0;
      end else if (is_topic) begin
         len_in = len_inc;
         if (req_bus.char_value == CH_NUL) begin
            ended_in = 1'b1;
         end
      end
   end

   // lowest active lane that matched
   always_comb begin
      fin_rsp.matched         = 1'b0;
      fin_rsp.first_match_res = '0;
      fin_rsp.topic_too_long  = pend_long_ff;
      for (int s = MAX_SUBS - 1; s >= 0; s--) begin
         if (hit_vec[s] && (s < int'(pend_count_ff)) && !pend_long_ff) begin
            fin_rsp.matched         = 1'b1;
            fin_rsp.first_match_res = IDX_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_count_ff <= active_ff;
      pend_long_ff  <= is_topic && (len_inc > LEN_W'(MAX_TOPIC_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         len_ff        <= '0;
         ended_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         len_ff        <= len_in;
         ended_ff      <= ended_in;
         pend_valid_ff <= ctl.restart;
      end
   end

   assign pop = rsp_bus.valid && rsp_bus.ready;

   mtfm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pend_valid_ff),
      .push_data (fin_rsp),
      .pop       (pop),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_bus.valid           = (q_count != '0);
   assign rsp_bus.matched         = head.matched;
   assign rsp_bus.first_match_res = head.first_match_res;
   assign rsp_bus.topic_too_long  = head.topic_too_long;

endmodule
